[rtl/scpr_pkg.sv]
// Shared types, constants and helper functions of the serial chain residual block.
`timescale 1ns / 1ps
package scpr_pkg;

   localparam int WORDS_PER_LINK = 12;
   localparam int TRANS_BASE     = 9;   // translation words follow the 3x3 rotation
   localparam int CORDIC_STEPS   = 30;

   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
   localparam logic signed [63:0] HALF_ULP    = 64'sd536870912;

   // configuration register indexes
   localparam logic [1:0] REG_TARGET_X = 2'd0;
   localparam logic [1:0] REG_TARGET_Y = 2'd1;
   localparam logic [1:0] REG_TARGET_Z = 2'd2;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef struct packed {
      logic mul_en;  // register a new product
      logic acc_en;  // fold the registered product into the sum
      logic clr;     // first term of a dot product
      logic sub;     // subtract instead of add
   } mac_ctrl_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               hit;
   } sat_type;

   function automatic sat_type sat32(input logic signed [40:0] v);
      sat_type r;
      r.hit = 1'b0;
      r.val = v[31:0];
      if (v > 41'sd2147483647) begin
         r.val = 32'sh7fffffff;
         r.hit = 1'b1;
      end else if (v < -41'sd2147483648) begin
         r.val = 32'sh80000000;
         r.hit = 1'b1;
      end
      return r;
   endfunction

   function automatic logic signed [35:0] atan_lut(input logic [4:0] idx);
      logic signed [35:0] r;
      case (idx)
         5'd0:    r = 36'sd843314857;
         5'd1:    r = 36'sd497837829;
         5'd2:    r = 36'sd263043837;
         5'd3:    r = 36'sd133525159;
         5'd4:    r = 36'sd67021687;
         5'd5:    r = 36'sd33543516;
         5'd6:    r = 36'sd16775851;
         5'd7:    r = 36'sd8388437;
         5'd8:    r = 36'sd4194283;
         5'd9:    r = 36'sd2097149;
         default: r = 36'sd1 <<< (5'd30 - idx);  // atan(2^-i) rounds to 2^(30-i)
      endcase
      return r;
   endfunction

endpackage

[rtl/scpr_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module scpr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 72
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end
endmodule

[rtl/scpr_mac.sv]
// Shared 32x32 multiplier with Q30 rounding and dot-product accumulator.
`timescale 1ns / 1ps
module scpr_mac (
   input  logic                        clock,
   input  logic signed [31:0]          opa,
   input  logic signed [31:0]          opb,
   input  scpr_pkg::mac_ctrl_type      ctrl,
   output logic signed [35:0]          sum
);
   import scpr_pkg::*;

   logic signed [63:0] prod_ff;
   logic signed [35:0] acc_ff;
   logic signed [63:0] biased;
   logic signed [35:0] rnd;
   logic signed [35:0] base;

   always_comb begin
      biased = prod_ff + HALF_ULP;
      rnd    = 36'($signed(biased[63:30]));  // floor shift: round half up
      base   = ctrl.clr ? 36'sd0 : acc_ff;
      sum    = ctrl.sub ? (base - rnd) : (base + rnd);
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= opa * opb;
      end
      if (ctrl.acc_en) begin
         acc_ff <= sum;
      end
   end
endmodule

[rtl/scpr_cordic.sv]
// Iterative sine/cosine unit: range reduction then 30 rotation-mode steps.
`timescale 1ns / 1ps
module scpr_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] angle,
   output logic               done,
   output logic signed [31:0] cos_o,
   output logic signed [31:0] sin_o
);
   import scpr_pkg::*;

   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_RED  = 2'd1;
   localparam logic [1:0] C_ITER = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [4:0]         step_ff, step_in;
   logic               neg_ff, neg_in;
   logic               done_ff, done_in;
   logic signed [35:0] z_ff, z_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] dx, dy;
   logic signed [33:0] xo, yo;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      done_in  = done_ff;
      z_in     = z_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      dx       = y_ff >>> step_ff;
      dy       = x_ff >>> step_ff;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               z_in     = 36'(angle) <<< 2;
               neg_in   = 1'b0;
               done_in  = 1'b0;
               state_in = C_RED;
            end
         end
         C_RED: begin
            // one wrap or fold per cycle
            if (z_ff > PI_Q30) begin
               z_in = z_ff - TWO_PI_Q30;
            end else if (z_ff < -PI_Q30) begin
               z_in = z_ff + TWO_PI_Q30;
            end else begin
               if (z_ff > HALF_PI_Q30) begin
                  z_in   = z_ff - PI_Q30;
                  neg_in = 1'b1;
               end else if (z_ff < -HALF_PI_Q30) begin
                  z_in   = z_ff + PI_Q30;
                  neg_in = 1'b1;
               end
               x_in     = GAIN_Q30;
               y_in     = 34'sd0;
               step_in  = 5'd0;
               state_in = C_ITER;
            end
         end
         C_ITER: begin
            if (!z_ff[35]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_lut(step_ff);
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_lut(step_ff);
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(CORDIC_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      neg_ff  <= neg_in;
      z_ff    <= z_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
   end

   always_comb begin
      xo    = neg_ff ? -x_ff : x_ff;
      yo    = neg_ff ? -y_ff : y_ff;
      cos_o = xo[31:0];
      sin_o = yo[31:0];
      done  = done_ff;
   end
endmodule

[rtl/serial_chain_position_residual.sv]
// Top level: six-joint forward kinematics position residual, one shared multiplier.
`timescale 1ns / 1ps
//  channel  handshake              payload
//  request  req_valid/req_ready    command, word_address, word_value, angle_0..angle_5
//  result   rsp_valid/rsp_ready    residual_x/y/z, overflow
//  config   csr_we (no handshake)  csr_index, csr_wdata
//
//  A load transaction writes the store directly. An evaluate transaction holds req_ready low
//  until it finishes: for each link it reads the link's 12 words from the store, forms
//  48 products in turn through the single 32x32 multiplier and passes the sin/cos
//  handoff; after the last link it forms the residual.
//  The sin/cos unit runs alongside the link's products.
//  Reset is synchronous and clears control state and the targets only.
//  A finished result sits in the output register; a new transaction is taken
//  meanwhile, and a second evaluate waits before its result if that is unread.
module serial_chain_position_residual #(
   parameter int NUM_LINKS = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic [6:0]         req_word_address,
   input  logic signed [31:0] req_word_value,
   input  logic signed [31:0] req_angle_0,
   input  logic signed [31:0] req_angle_1,
   input  logic signed [31:0] req_angle_2,
   input  logic signed [31:0] req_angle_3,
   input  logic signed [31:0] req_angle_4,
   input  logic signed [31:0] req_angle_5,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_residual_x,
   output logic signed [31:0] rsp_residual_y,
   output logic signed [31:0] rsp_residual_z,
   output logic               rsp_overflow,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import scpr_pkg::*;

   localparam int DEPTH  = NUM_LINKS * WORDS_PER_LINK;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int KW     = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;  // read link words into registers
   localparam logic [2:0] S_PMAC  = 3'd2;  // p += M * t
   localparam logic [2:0] S_RMAC  = 3'd3;  // A = sat(M * R)
   localparam logic [2:0] S_WAIT  = 3'd4;  // sin/cos not ready yet
   localparam logic [2:0] S_ZMAC  = 3'd5;  // M = sat(A * Rz)
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [3:0]         f_ff, f_in;
   logic [1:0]         i_ff, i_in, j_ff, j_in, n_ff, n_in;
   logic               ph_ff, ph_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic signed [31:0] target_ff [3];
   logic signed [31:0] angle_ff  [NUM_LINKS];
   logic signed [31:0] angles_all [6];
   logic signed [31:0] w_ff [WORDS_PER_LINK];
   logic signed [31:0] m_ff [3][3];
   logic signed [31:0] a_ff [3][3];
   logic signed [39:0] p_ff [3];
   logic signed [31:0] res_ff [3];
   logic               ovf_ff;

   logic               accept, do_eval, do_load, in_mac, last_n, fin_go;
   logic [ADDR_W-1:0]  raddr;
   logic [31:0]        rdata;
   logic signed [31:0] opa, opb;
   logic signed [35:0] mac_sum;
   mac_ctrl_type       mac_ctrl;
   sat_type            sat_w;
   sat_type            res_sat [3];
   logic               cs_start, cs_done;
   logic signed [31:0] cs_cos, cs_sin;

   assign angles_all[0] = req_angle_0;
   assign angles_all[1] = req_angle_1;
   assign angles_all[2] = req_angle_2;
   assign angles_all[3] = req_angle_3;
   assign angles_all[4] = req_angle_4;
   assign angles_all[5] = req_angle_5;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign do_eval   = accept && (req_command == CMD_EVAL);
   assign do_load   = accept && (req_command == CMD_LOAD) && (req_word_address < 7'(DEPTH));
   assign in_mac    = (state_ff == S_PMAC) || (state_ff == S_RMAC) || (state_ff == S_ZMAC);
   assign last_n    = (state_ff == S_ZMAC) ? (n_ff == 2'd1) : (n_ff == 2'd2);
   assign fin_go    = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);
   assign raddr     = ADDR_W'(32'(k_ff) * WORDS_PER_LINK + 32'(f_ff));
   assign cs_start  = (state_ff == S_FETCH) && (f_ff == 4'd0);

   scpr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
      .clock    (clock),
      .we       (do_load),
      .waddr    (req_word_address[ADDR_W-1:0]),
      .wdata    (req_word_value),
      .raddr    (raddr),
      .rdata_ff (rdata)
   );

   scpr_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cs_start),
      .angle (angle_ff[k_ff]),
      .done  (cs_done),
      .cos_o (cs_cos),
      .sin_o (cs_sin)
   );

   // operand select for the shared multiplier
   always_comb begin
      opa = 32'sd0;
      opb = 32'sd0;
      case (state_ff)
         S_PMAC: begin
            opa = m_ff[i_ff][n_ff];
            opb = w_ff[4'(TRANS_BASE) + 4'(n_ff)];
         end
         S_RMAC: begin
            opa = m_ff[i_ff][n_ff];
            opb = w_ff[4'(n_ff) * 4'd3 + 4'(j_ff)];
         end
         S_ZMAC: begin
            // col 0: a0*c + a1*s ; col 1: a1*c - a0*s
            opa = (j_ff[0] == n_ff[0]) ? a_ff[i_ff][0] : a_ff[i_ff][1];
            opb = n_ff[0] ? cs_sin : cs_cos;
         end
         default: ;
      endcase
      mac_ctrl.mul_en = in_mac && !ph_ff;
      mac_ctrl.acc_en = in_mac && ph_ff;
      mac_ctrl.clr    = (n_ff == 2'd0);
      mac_ctrl.sub    = (state_ff == S_ZMAC) && j_ff[0] && n_ff[0];
   end

   scpr_mac u_mac (
      .clock (clock),
      .opa   (opa),
      .opb   (opb),
      .ctrl  (mac_ctrl),
      .sum   (mac_sum)
   );

   always_comb begin
      sat_w = sat32(41'(mac_sum));
      for (int q = 0; q < 3; q++) begin
         res_sat[q] = sat32(41'(p_ff[q]) - 41'(target_ff[q]));
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      f_in         = f_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      ph_in        = ph_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (do_eval) begin
               k_in     = '0;
               f_in     = 4'd0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            f_in = f_ff + 4'd1;
            if (f_ff == 4'(WORDS_PER_LINK)) begin
               i_in     = 2'd0;
               j_in     = 2'd0;
               n_in     = 2'd0;
               ph_in    = 1'b0;
               state_in = S_PMAC;
            end
         end
         S_PMAC, S_RMAC, S_ZMAC: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               n_in = n_ff + 2'd1;
               if (last_n) begin
                  n_in = 2'd0;
                  case (state_ff)
                     S_PMAC: begin
                        i_in = i_ff + 2'd1;
                        if (i_ff == 2'd2) begin
                           i_in     = 2'd0;
                           state_in = S_RMAC;
                        end
                     end
                     S_RMAC: begin
                        j_in = j_ff + 2'd1;
                        if (j_ff == 2'd2) begin
                           j_in = 2'd0;
                           i_in = i_ff + 2'd1;
                           if (i_ff == 2'd2) begin
                              i_in     = 2'd0;
                              state_in = S_WAIT;
                           end
                        end
                     end
                     default: begin
                        j_in = j_ff + 2'd1;
                        if (j_ff == 2'd1) begin
                           j_in = 2'd0;
                           i_in = i_ff + 2'd1;
                           if (i_ff == 2'd2) begin
                              i_in = 2'd0;
                              f_in = 4'd0;
                              k_in = k_ff + KW'(1);
                              state_in = (k_ff == KW'(NUM_LINKS - 1)) ? S_FIN : S_FETCH;
                           end
                        end
                     end
                  endcase
               end
            end
         end
         S_WAIT: begin
            if (cs_done) begin
               ph_in    = 1'b0;
               state_in = S_ZMAC;
            end
         end
         S_FIN: begin
            if (fin_go) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         f_ff         <= 4'd0;
         i_ff         <= 2'd0;
         j_ff         <= 2'd0;
         n_ff         <= 2'd0;
         ph_ff        <= 1'b0;
         for (int q = 0; q < 3; q++) begin
            target_ff[q] <= 32'sd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         f_ff         <= f_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         ph_ff        <= ph_in;
         if (csr_we) begin
            case (csr_index)
               REG_TARGET_X: target_ff[0] <= csr_wdata;
               REG_TARGET_Y: target_ff[1] <= csr_wdata;
               REG_TARGET_Z: target_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (do_eval) begin
         for (int q = 0; q < NUM_LINKS; q++) begin
            angle_ff[q] <= angles_all[q];
         end
         for (int r = 0; r < 3; r++) begin
            p_ff[r] <= 40'sd0;
            for (int c = 0; c < 3; c++) begin
               m_ff[r][c] <= (r == c) ? ONE_Q30 : 32'sd0;
            end
         end
      end
      if ((state_ff == S_FETCH) && (f_ff != 4'd0)) begin
         w_ff[f_ff - 4'd1] <= rdata;
      end
      if (in_mac && ph_ff && last_n) begin
         case (state_ff)
            S_PMAC:  p_ff[i_ff] <= p_ff[i_ff] + 40'(mac_sum);
            S_RMAC:  a_ff[i_ff][j_ff] <= sat_w.val;
            default: begin
               m_ff[i_ff][j_ff] <= sat_w.val;
               if (j_ff == 2'd1) begin
                  m_ff[i_ff][2] <= a_ff[i_ff][2];
               end
            end
         endcase
      end
      if (fin_go) begin
         for (int q = 0; q < 3; q++) begin
            res_ff[q] <= res_sat[q].val;
         end
         ovf_ff <= res_sat[0].hit | res_sat[1].hit | res_sat[2].hit;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_residual_x = res_ff[0];
   assign rsp_residual_y = res_ff[1];
   assign rsp_residual_z = res_ff[2];
   assign rsp_overflow   = ovf_ff;
endmodule

[test/testbench.sv]
// Self-checking testbench for the six-joint position residual block.
`timescale 1ns / 1ps
module testbench;
   import scpr_pkg::*;

   localparam int      NLINK      = 6;
   localparam int      DEPTH      = NLINK * WORDS_PER_LINK;
   localparam logic [1:0] REG_NONE = 2'd3;     // unused register slot, writes ignored
   localparam int      IDLE_LIMIT = 20000;    // cycles with no transaction on either side
   localparam int      LONG_HOLD  = 3000;
   localparam longint  Q30_ONE    = 64'sd1073741824;
   localparam longint  ROUND_HALF = 64'sd536870912;
   localparam longint  ANG_PI     = 64'sd3373259426;
   localparam longint  ANG_2PI    = 64'sd6746518852;
   localparam longint  ANG_HPI    = 64'sd1686629713;
   localparam longint  KGAIN      = 64'sd652032874;
   localparam longint  ARCTAN [30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536,
      32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

   typedef struct {
      logic        cmd;
      logic [6:0]  addr;
      logic [31:0] value;
      logic [31:0] angle [6];
   } arm_req_type;

   typedef struct {
      logic [31:0] rx, ry, rz;
      logic        ovf;
   } residual_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = CMD_LOAD;
   logic [6:0]  req_word_address = '0;
   logic signed [31:0] req_word_value = '0;
   logic signed [31:0] req_angle_0 = '0, req_angle_1 = '0, req_angle_2 = '0;
   logic signed [31:0] req_angle_3 = '0, req_angle_4 = '0, req_angle_5 = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [31:0] rsp_residual_x, rsp_residual_y, rsp_residual_z;
   logic        rsp_overflow;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_TARGET_X;
   logic [31:0] csr_wdata = '0;

   serial_chain_position_residual dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mirror of the block's state
   logic [31:0] link_words [DEPTH];
   longint      tgt [3];

   arm_req_type  pending_reqs [$];
   residual_type expected_residuals [$];
   arm_req_type  cur_req;
   bit          req_took = 0;      // set at the rising edge when a request transaction went in
   int          mismatches = 0;
   int          n_loads = 0, n_evals = 0, n_results = 0, n_sat = 0;
   bit          long_hold_go = 0;
   bit          sender_hold = 0;

   // ---------------------------------------------------------------- arithmetic
   function automatic longint mulq(longint a, longint b);
      return (a * b + ROUND_HALF) >>> 30;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint word_at(int idx);
      return longint'($signed(link_words[idx]));
   endfunction

   // CORDIC sine/cosine, Q4.28 angle in, Q2.30 out
   task automatic joint_sincos(input logic [31:0] ang, output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit     flip;
      z = longint'($signed(ang)) * 4;
      x = KGAIN;
      y = 0;
      flip = 0;
      if (z > ANG_PI) z -= ANG_2PI;
      if (z > ANG_PI) z -= ANG_2PI;
      if (z < -ANG_PI) z += ANG_2PI;
      if (z < -ANG_PI) z += ANG_2PI;
      if (z > ANG_HPI) begin
         z -= ANG_PI;
         flip = 1;
      end else if (z < -ANG_HPI) begin
         z += ANG_PI;
         flip = 1;
      end
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ARCTAN[i];
         end else begin
            x += dx; y -= dy; z += ARCTAN[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   // walk the chain and form end position minus target
   task automatic chain_residual(input arm_req_type r, output residual_type res);
      longint m [3][3];
      longint a [3][3];
      longint p [3];
      longint acc, c, s, d;
      res.ovf = 0;
      for (int i = 0; i < 3; i++) begin
         p[i] = 0;
         for (int j = 0; j < 3; j++) m[i][j] = (i == j) ? Q30_ONE : 0;
      end
      for (int k = 0; k < NLINK; k++) begin
         for (int i = 0; i < 3; i++)
            for (int n = 0; n < 3; n++)
               p[i] += mulq(m[i][n], word_at(k * WORDS_PER_LINK + TRANS_BASE + n));
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               acc = 0;
               for (int n = 0; n < 3; n++)
                  acc += mulq(m[i][n], word_at(k * WORDS_PER_LINK + n * 3 + j));
               a[i][j] = clamp32(acc);
            end
         joint_sincos(r.angle[k], c, s);
         for (int i = 0; i < 3; i++) begin
            m[i][0] = clamp32(mulq(a[i][0], c) + mulq(a[i][1], s));
            m[i][1] = clamp32(mulq(a[i][1], c) - mulq(a[i][0], s));
            m[i][2] = a[i][2];
         end
      end
      for (int i = 0; i < 3; i++) begin
         d = p[i] - tgt[i];
         if (clamp32(d) != d) res.ovf = 1;
         p[i] = clamp32(d);
      end
      res.rx = p[0][31:0];
      res.ry = p[1][31:0];
      res.rz = p[2][31:0];
   endtask

   // ---------------------------------------------------------------- stimulus helpers
   function automatic logic [31:0] rot_word();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1, 2: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
         3: return ($urandom_range(0, 1)) ? 32'h4000_0000 : 32'hC000_0000;
         default: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   function automatic logic [31:0] trans_word();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      endcase
   endfunction

   function automatic arm_req_type mk_load(int addr, logic [31:0] v);
      arm_req_type r;
      r.cmd = CMD_LOAD;
      r.addr = addr[6:0];
      r.value = v;
      foreach (r.angle[k]) r.angle[k] = $urandom;   // ignored by a load
      return r;
   endfunction

   function automatic arm_req_type mk_eval();
      arm_req_type r;
      r.cmd = CMD_EVAL;
      r.addr = 7'($urandom);                          // ignored by an evaluate
      r.value = $urandom;
      foreach (r.angle[k])
         r.angle[k] = ($urandom_range(0, 2) == 0) ? $urandom
                                                  : $urandom_range(0, 32'h6000_0000) - 32'h3000_0000;
      return r;
   endfunction

   // append one transaction to the driver's queue
   task automatic add_pending(arm_req_type r);
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic push_link(int k);
      for (int w = 0; w < WORDS_PER_LINK; w++)
         add_pending(mk_load(k * WORDS_PER_LINK + w,
                             (w < TRANS_BASE) ? rot_word() : trans_word()));
   endtask

   // register write, only while the block is idle
   task automatic csr_write(logic [1:0] idx, logic [31:0] v);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx != REG_NONE) tgt[idx] = longint'($signed(v));
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && !req_valid && expected_residuals.size() == 0);
      repeat (50) @(posedge clock);    // let a trailing load settle
   endtask

   // ---------------------------------------------------------------- request driver
   int burst_left = 0, gap_left = 0;
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_took)) begin
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         end
         if (gap_left > 0 || sender_hold || pending_reqs.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            burst_left--;
            cur_req = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_command <= cur_req.cmd;
            req_word_address <= cur_req.addr;
            req_word_value <= cur_req.value;
            req_angle_0 <= cur_req.angle[0];
            req_angle_1 <= cur_req.angle[1];
            req_angle_2 <= cur_req.angle[2];
            req_angle_3 <= cur_req.angle[3];
            req_angle_4 <= cur_req.angle[4];
            req_angle_5 <= cur_req.angle[5];
         end
      end
   end

   // ---------------------------------------------------------------- result receiver
   int hold_cnt = 0, stall_mode = 0, mode_left = 0;
   bit long_hold_done = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold_go && !long_hold_done) begin
         // long back-pressure: block must fill and stall its request side
         hold_cnt++;
         rsp_ready <= 1'b0;
         if (hold_cnt >= LONG_HOLD) long_hold_done = 1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 2000);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (mode_left % 300) < 150;
         endcase
      end
   end

   // ---------------------------------------------------------------- monitor + predictor
   int idle_cycles = 0;
   always @(posedge clock) begin
      residual_type want;
      req_took = req_valid && req_ready;
      if (!reset) begin
         if (req_took) begin
            if (req_command == CMD_LOAD) begin
               n_loads++;
               if (req_word_address < DEPTH) link_words[req_word_address] = req_word_value;
            end else begin
               n_evals++;
               chain_residual(cur_req, want);
               expected_residuals = {expected_residuals, want};
            end
         end
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (expected_residuals.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: result transaction with none expected at %0t", $realtime);
            end else begin
               want = expected_residuals.pop_front();
               if (want.ovf) n_sat++;
               if (rsp_residual_x !== want.rx || rsp_residual_y !== want.ry ||
                   rsp_residual_z !== want.rz || rsp_overflow !== want.ovf) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: result %0d got x=%h y=%h z=%h ovf=%b, want x=%h y=%h z=%h ovf=%b",
                              n_results, rsp_residual_x, rsp_residual_y, rsp_residual_z,
                              rsp_overflow, want.rx, want.ry, want.rz, want.ovf);
               end
            end
         end
         // watchdog
         if (req_took || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("** serial_chain_position_residual: FAILED **");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- test sequence
   initial begin
      arm_req_type r;
      logic [31:0] tvals [6];
      tgt = '{0, 0, 0};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_write(REG_TARGET_X, 32'd0);
      csr_write(REG_TARGET_Y, 32'd0);
      csr_write(REG_TARGET_Z, 32'd0);
      csr_write(REG_NONE, 32'hDEAD_BEEF);   // unused slot, must not disturb targets

      // directed: identity links, then extreme angles and translations
      for (int k = 0; k < NLINK; k++)
         for (int w = 0; w < WORDS_PER_LINK; w++)
            add_pending(mk_load(k * WORDS_PER_LINK + w,
               (w == 0 || w == 4 || w == 8) ? 32'h4000_0000 :
               (w >= TRANS_BASE) ? 32'h0100_0000 * (w - 8) : 32'h0));
      r = mk_eval();
      foreach (r.angle[k]) r.angle[k] = 32'h0;
      add_pending(r);
      foreach (r.angle[k]) r.angle[k] = (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      add_pending(r);
      // angles near +-pi/2 and +-pi (Q4.28)
      tvals = '{32'h1921_FB54, 32'hE6DE_04AC, 32'h3243_F6A9, 32'hCDBC_0957,
                32'h1921_FB55, 32'h3243_F6A8};
      foreach (r.angle[k]) r.angle[k] = tvals[k];
      add_pending(r);
      add_pending(mk_load(72, 32'hFFFF_FFFF));    // out-of-range address
      add_pending(mk_load(127, 32'h1234_5678));
      add_pending(mk_load(TRANS_BASE, 32'h7FFF_FFFF));
      add_pending(mk_load(TRANS_BASE + 1, 32'h8000_0000));
      add_pending(mk_load(0, 32'h7FFF_FFFF));     // saturating rotation entry
      add_pending(mk_eval());
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               tvals[0] = $urandom;
               tvals[1] = $urandom;
               tvals[2] = $urandom;
            end
            1: begin
               tvals[0] = 32'h7FFF_FFFF;
               tvals[1] = 32'h8000_0000;
               tvals[2] = 32'h7FFF_FFFF;
            end
            2: begin
               tvals[0] = 32'h8000_0000;
               tvals[1] = 32'h7FFF_FFFF;
               tvals[2] = 32'h8000_0000;
            end
            3: begin
               tvals[0] = 32'h0;
               tvals[1] = 32'h0;
               tvals[2] = 32'h0;
            end
            default: begin
               tvals[0] = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
               tvals[1] = $urandom;
               tvals[2] = $urandom_range(0, 32'h0800_0000);
            end
         endcase
         csr_write(REG_TARGET_X, tvals[0]);
         csr_write(REG_TARGET_Y, tvals[1]);
         csr_write(REG_TARGET_Z, tvals[2]);
         if (ph == 2) long_hold_go = 1;
         // mostly whole-link reloads followed by evaluates, also bare evaluates and stray loads
         while (pending_reqs.size() < 215) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  push_link($urandom_range(0, NLINK - 1));
                  add_pending(mk_eval());
               end
               4, 5, 6: add_pending(mk_eval());
               7: add_pending(mk_load($urandom_range(0, DEPTH - 1), $urandom));
               default: add_pending(mk_load($urandom_range(DEPTH, 127), $urandom));
            endcase
         end
         // sender pauses mid-phase until every outstanding result is back
         if (ph == 3) begin
            wait (pending_reqs.size() < 100);
            sender_hold = 1;
            wait (!req_valid && expected_residuals.size() == 0);
            repeat (20) @(posedge clock);
            sender_hold = 0;
         end
         drain();
      end

      repeat (800) @(posedge clock);
      $display("run covered %0d loads and %0d evaluates, %0d results checked (%0d saturated)",
               n_loads, n_evals, n_results, n_sat);
      $display("five target settings incl. both extremes, long output back-pressure");
      if (mismatches == 0 && expected_residuals.size() == 0) begin
         $display("** serial_chain_position_residual: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_residuals.size());
         $display("** serial_chain_position_residual: FAILED **");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/scpr_pkg.sv
rtl/scpr_ram.sv
rtl/scpr_mac.sv
rtl/scpr_cordic.sv
rtl/serial_chain_position_residual.sv
test/testbench.sv
